FILE: rtl/core/cms_pkg.sv
// ----------------------------------------------------------------------------
// Column band check package
// Shared widths, fixed-point constants, operation and command codes, and the
// structures that pass between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int COL_W       = 12;
    localparam int CC_W        = 13;
    localparam int GAIN_W      = 10;
    localparam int DIFF_W      = 11;
    localparam int MEAN_W      = 16;
    localparam int VAR_W       = 24;
    localparam int BAND_W      = 12;
    localparam int ROWS_W      = 16;
    localparam int K_W         = ROWS_W + 1;
    localparam int MEAN_FRAC   = 16 - PIXEL_BITS;
    localparam int VAR_FRAC    = 24 - 2 * PIXEL_BITS;
    localparam int SD_FRAC     = VAR_FRAC / 2;
    localparam int BAND_FRAC   = SD_FRAC + 8;
    localparam int MEAN_ALIGN  = BAND_FRAC - MEAN_FRAC;
    localparam int SQ_SHIFT    = 2 * MEAN_FRAC - VAR_FRAC;

    // Reciprocals are floor(2^RECIP_SHIFT / k); every dividend stays below 2^RECIP_SHIFT.
    localparam int RECIP_SHIFT = 25;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int NUM_W       = RECIP_SHIFT;
    localparam int PROD_W      = NUM_W + RECIP_W;
    localparam int DD_W        = MEAN_W;
    localparam int SQ_W        = 2 * DD_W;

    localparam int SQRT_IN_W   = VAR_W + 2;
    localparam int SQRT_OUT_W  = SQRT_IN_W / 2;
    localparam int SD_W        = SQRT_OUT_W;
    localparam int HALF_W      = SD_W + GAIN_W;
    localparam int BANDV_W     = HALF_W + 2;

    localparam logic [GAIN_W-1:0] GAIN_MIN   = GAIN_W'(26);
    localparam logic [GAIN_W-1:0] GAIN_MAX   = GAIN_W'(768);
    localparam logic [ROWS_W-1:0] ROWS_MAX   = '1;
    localparam logic [VAR_W-1:0]  VAR_MAX    = '1;
    localparam logic [CC_W-1:0]   CC_RESET   = CC_W'(4096);
    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

    typedef enum logic [1:0] {
        OP_TRAIN   = 2'd0,
        OP_FINISH  = 2'd1,
        OP_CHECK   = 2'd2,
        OP_RESTART = 2'd3
    } t_op;

    typedef enum logic {
        CFG_COLUMN_COUNT = 1'b0,
        CFG_SIGMA_GAIN   = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        CMD_TRAIN,
        CMD_ROWS,
        CMD_FINISH,
        CMD_CHECK,
        CMD_RESTART
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind             kind;
        logic [COL_W-1:0]      column;
        logic [PIXEL_BITS-1:0] pixel;
        logic                  end_of_row;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        t_cmd cmd;
    } t_queue_head;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

    typedef enum logic [4:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_TRAIN_RD,
        BK_TRAIN_D,
        BK_TRAIN_SQ,
        BK_DIV_MUL,
        BK_DIV_BACK,
        BK_DIV_FIX,
        BK_TRAIN_WR,
        BK_ROWS,
        BK_RECIP,
        BK_FIN_RD,
        BK_FIN_ROOT,
        BK_FIN_WAIT,
        BK_FIN_MUL,
        BK_FIN_BAND,
        BK_CHK_RD,
        BK_CHK_OUT
    } t_back_state;

endpackage

`default_nettype wire

FILE: rtl/core/cms_recip.sv
// ----------------------------------------------------------------------------
// Row reciprocal unit
// Restoring divider that forms floor(2^RECIP_SHIFT / k), one quotient bit per
// cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_recip (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cms_pkg::K_W-1:0]     i_divisor,
    output logic                        o_done,
    output logic [cms_pkg::RECIP_W-1:0] o_quot
);
    import cms_pkg::*;

    localparam int CNT_W = $clog2(RECIP_SHIFT + 1);

    logic               r_busy;
    logic               r_done;
    logic [CNT_W-1:0]   r_cnt;
    logic [K_W-1:0]     r_den;
    logic [K_W-1:0]     r_rem;
    logic [RECIP_W-1:0] r_quot;
    logic [K_W:0]       shifted;
    logic               fits;

    // The dividend is a single one at the top bit position.
    assign shifted = {r_rem, (r_cnt == CNT_W'(RECIP_SHIFT))};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_den  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
            r_cnt  <= CNT_W'(RECIP_SHIFT);
        end else if (r_busy) begin
            r_rem  <= fits ? K_W'(shifted - {1'b0, r_den}) : shifted[K_W-1:0];
            r_quot <= {r_quot[RECIP_W-2:0], fits};
            r_cnt  <= r_cnt - CNT_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

FILE: rtl/core/cms_isqrt.sv
// ----------------------------------------------------------------------------
// Integer square root unit
// Digit-by-digit square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_isqrt (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cms_pkg::SQRT_IN_W-1:0]  i_value,
    output logic                           o_done,
    output logic [cms_pkg::SQRT_OUT_W-1:0] o_root
);
    import cms_pkg::*;

    localparam int STEP_W = $clog2(SQRT_OUT_W);

    logic                  r_busy;
    logic                  r_done;
    logic [STEP_W-1:0]     r_step;
    logic [SQRT_IN_W-1:0]  r_rem;
    logic [SQRT_IN_W-1:0]  r_res;
    logic [SQRT_IN_W-1:0]  r_bit;
    logic [SQRT_IN_W:0]    trial;
    logic                  take;

    assign trial = {1'b0, r_res} + {1'b0, r_bit};
    assign take  = {1'b0, r_rem} >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_value;
            r_res  <= '0;
            r_bit  <= SQRT_IN_W'(1) << (SQRT_IN_W - 2);
            r_step <= STEP_W'(SQRT_OUT_W - 1);
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - trial[SQRT_IN_W-1:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit  <= r_bit >> 2;
            r_step <= r_step - STEP_W'(1);
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[SQRT_OUT_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/cms_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts items, drops those that have no effect, classifies the rest and
// holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_front #(
    parameter int ADDR_W = 12
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [1:0]                     i_operation,
    input  logic [cms_pkg::COL_W-1:0]      i_column,
    input  logic [cms_pkg::PIXEL_BITS-1:0] i_pixel,
    input  logic                           i_end_of_row,
    input  logic [ADDR_W-1:0]              i_col_last,
    input  cms_pkg::t_back_ctl             i_back,
    output cms_pkg::t_queue_head           o_head
);
    import cms_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    t_cmd             r_q [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             accept;
    logic             col_ok;
    logic             push;
    logic             pop;
    t_cmd             item;

    assign col_ok = 16'(i_column) <= 16'(i_col_last);
    assign accept = i_start && !o_busy;
    assign pop    = i_back.pop && (r_count != '0);

    always_comb begin
        item.column     = i_column;
        item.pixel      = i_pixel;
        item.end_of_row = i_end_of_row;
        item.kind       = CMD_RESTART;
        push            = 1'b0;
        unique case (t_op'(i_operation))
            OP_TRAIN: begin
                // An out-of-range column still advances the row count.
                item.kind = col_ok ? CMD_TRAIN : CMD_ROWS;
                push      = accept && (col_ok || i_end_of_row);
            end
            OP_FINISH: begin
                item.kind = CMD_FINISH;
                push      = accept;
            end
            OP_CHECK: begin
                item.kind = CMD_CHECK;
                push      = accept && col_ok;
            end
            OP_RESTART: begin
                item.kind = CMD_RESTART;
                push      = accept;
            end
            default: begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= item;
        end
    end

    assign o_busy           = (r_count == (PTR_W + 1)'(DEPTH)) || i_back.clearing;
    assign o_head.not_empty = r_count != '0;
    assign o_head.cmd       = r_q[r_rd_ptr];

endmodule

`default_nettype wire

FILE: rtl/core/cms_back.sv
// ----------------------------------------------------------------------------
// Command back end
// Runs the Welford update, band building and band checks against the column
// memories, one command at a time.
// ----------------------------------------------------------------------------
`default_nettype none

module cms_back #(
    parameter int MAX_COLUMNS = 4096,
    parameter int ADDR_W      = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cms_pkg::t_queue_head              i_head,
    output cms_pkg::t_back_ctl                o_ctl,
    input  logic [ADDR_W-1:0]                 i_col_last,
    input  logic [cms_pkg::GAIN_W-1:0]        i_gain,
    output logic                              o_strobe,
    output logic signed [cms_pkg::DIFF_W-1:0] o_pixel_diff,
    output logic                              o_out_of_band
);
    import cms_pkg::*;

    localparam int MV_W = MEAN_W + VAR_W;
    localparam int BD_W = 2 * BAND_W;
    localparam logic [1:0] JOB_MEAN   = 2'd0;
    localparam logic [1:0] JOB_SPREAD = 2'd1;
    localparam logic [1:0] JOB_SCALE  = 2'd2;

    logic [MV_W-1:0] r_mv_mem [MAX_COLUMNS];
    logic [BD_W-1:0] r_bd_mem [MAX_COLUMNS];
    logic [MV_W-1:0] r_mv_q;
    logic [BD_W-1:0] r_bd_q;

    t_back_state r_state, n_state;
    logic [ADDR_W-1:0]  r_addr;
    logic [ROWS_W-1:0]  r_rows;
    logic [RECIP_W-1:0] r_rk;
    logic [RECIP_W-1:0] r_rkm1;
    logic               r_strobe;

    logic [PIXEL_BITS-1:0]    r_pixel;
    logic                     r_eor;
    logic signed [K_W-1:0]    r_d;
    logic [MEAN_W-1:0]        r_mean_old;
    logic [VAR_W-1:0]         r_var_old;
    logic [SQ_W-1:0]          r_sq;
    logic [1:0]               r_job;
    logic [NUM_W-1:0]         r_num;
    logic [K_W-1:0]           r_den;
    logic [PROD_W-1:0]        r_prod;
    logic [NUM_W-1:0]         r_q0;
    logic [NUM_W-1:0]         r_qk;
    logic [NUM_W-1:0]         r_qm;
    logic [NUM_W-1:0]         r_qt1;
    logic [NUM_W-1:0]         r_qt2;
    logic [SD_W-1:0]          r_sd;
    logic [HALF_W-1:0]        r_half;
    logic signed [DIFF_W-1:0] r_diff;
    logic                     r_oob;

    logic               mv_we;
    logic [MV_W-1:0]    mv_wdata;
    logic               bd_we;
    logic [BD_W-1:0]    bd_wdata;
    logic               recip_start;
    logic               recip_done;
    logic [RECIP_W-1:0] recip_quot;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [SD_W-1:0]    sqrt_root;

    logic [K_W-1:0]     k_cur;
    logic [DD_W-1:0]    dd;
    logic [NUM_W-1:0]   num;
    logic [K_W-1:0]     den;
    logic [RECIP_W-1:0] recip;
    logic [NUM_W-1:0]   rem;
    logic [NUM_W-1:0]   q_fixed;
    logic               last_col;

    logic signed [K_W:0]         mean_sum;
    logic [MEAN_W-1:0]           mean_new;
    logic [VAR_W:0]              var_keep;
    logic [NUM_W+1:0]            var_sum;
    logic [VAR_W-1:0]            var_new;
    logic signed [BANDV_W-1:0]   mc_s;
    logic signed [BANDV_W-1:0]   half_s;
    logic [BAND_W-1:0]           band_lo;
    logic [BAND_W-1:0]           band_hi;
    logic signed [BAND_W:0]      p_s;
    logic signed [BAND_W:0]      lo_s;
    logic signed [BAND_W:0]      hi_s;
    logic signed [BAND_W:0]      diff_raw;
    logic signed [DIFF_W-1:0]    diff_sat;

    function automatic logic [BAND_W-1:0] band_round(input logic signed [BANDV_W-1:0] v);
        logic signed [BANDV_W-1:0]         t;
        logic signed [BANDV_W-BAND_FRAC-1:0] r;
        t = v + BANDV_W'(1 << (BAND_FRAC - 1));
        r = t[BANDV_W-1:BAND_FRAC];
        if (r < -(BANDV_W - BAND_FRAC)'(1 << (BAND_W - 1))) begin
            band_round = {1'b1, {(BAND_W - 1){1'b0}}};
        end else if (r > (BANDV_W - BAND_FRAC)'((1 << (BAND_W - 1)) - 1)) begin
            band_round = {1'b0, {(BAND_W - 1){1'b1}}};
        end else begin
            band_round = r[BAND_W-1:0];
        end
    endfunction

    cms_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (recip_start),
        .i_divisor (K_W'(r_rows) + K_W'(2)),
        .o_done    (recip_done),
        .o_quot    (recip_quot)
    );

    cms_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value ({r_mv_q[VAR_W-1:0], 2'b00}),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    // Column memories: one write port and one registered read port each.
    always_ff @(posedge i_clk) begin
        if (mv_we) begin
            r_mv_mem[r_addr] <= mv_wdata;
        end
        r_mv_q <= r_mv_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (bd_we) begin
            r_bd_mem[r_addr] <= bd_wdata;
        end
        r_bd_q <= r_bd_mem[r_addr];
    end

    // Division by k or k-1 uses the stored reciprocal and one correction step.
    assign k_cur = K_W'(r_rows) + K_W'(1);
    assign dd    = DD_W'(r_d < 0 ? -r_d : r_d);

    always_comb begin
        case (r_job)
            JOB_MEAN: begin
                num   = NUM_W'(dd) + NUM_W'(k_cur >> 1);
                den   = k_cur;
                recip = r_rk;
            end
            JOB_SPREAD: begin
                num   = NUM_W'(((SQ_W + 1)'(r_sq) + ((SQ_W + 1)'(k_cur) << (SQ_SHIFT - 1)))
                        >> SQ_SHIFT);
                den   = k_cur;
                recip = r_rk;
            end
            default: begin
                // round(var*(k-2)/(k-1)) = var - floor((var + k - 2 - (k-1)/2) / (k-1))
                num   = NUM_W'(r_var_old) + NUM_W'(r_rows) - NUM_W'(1)
                        - NUM_W'(r_rows >> 1);
                den   = K_W'(r_rows);
                recip = r_rkm1;
            end
        endcase
    end

    assign rem     = r_num - r_qk;
    assign q_fixed = r_q0 + NUM_W'(rem >= NUM_W'(r_den));

    // Training write-back values; the clearing pass writes zeroes instead.
    always_comb begin
        mean_sum = (K_W + 1)'(signed'({2'b00, r_mean_old}));
        if (r_d < 0) begin
            mean_sum = mean_sum - (K_W + 1)'(signed'({1'b0, r_qm[K_W-1:0]}));
        end else begin
            mean_sum = mean_sum + (K_W + 1)'(signed'({1'b0, r_qm[K_W-1:0]}));
        end
        if (mean_sum < 0) begin
            mean_new = '0;
        end else if (mean_sum > (K_W + 1)'(signed'({2'b00, {MEAN_W{1'b1}}}))) begin
            mean_new = '1;
        end else begin
            mean_new = mean_sum[MEAN_W-1:0];
        end

        var_keep = (VAR_W + 1)'(r_var_old) - (VAR_W + 1)'(r_qt1);
        var_sum  = (NUM_W + 2)'(var_keep) + (NUM_W + 2)'(r_qt2);
        if (r_rows == '0) begin
            var_new = '0;
        end else if (var_sum > (NUM_W + 2)'(VAR_MAX)) begin
            var_new = VAR_MAX;
        end else begin
            var_new = var_sum[VAR_W-1:0];
        end
        mv_wdata = {mean_new, var_new};
        if (r_state == BK_CLEAR) begin
            mv_wdata = '0;
        end
    end

    // Band edges from the stored mean and the scaled deviation.
    assign mc_s    = signed'(BANDV_W'({r_mean_old, {MEAN_ALIGN{1'b0}}}));
    assign half_s  = signed'(BANDV_W'(r_half));
    assign band_lo = band_round(mc_s - half_s);
    assign band_hi = band_round(mc_s + half_s);

    // Check against the stored band.
    always_comb begin
        p_s  = signed'((BAND_W + 1)'(r_pixel));
        lo_s = signed'({r_bd_q[BD_W-1], r_bd_q[BD_W-1:BAND_W]});
        hi_s = signed'({r_bd_q[BAND_W-1], r_bd_q[BAND_W-1:0]});
        if (p_s < lo_s) begin
            diff_raw = p_s - lo_s;
        end else if (p_s > hi_s) begin
            diff_raw = p_s - hi_s;
        end else begin
            diff_raw = '0;
        end
        if (diff_raw > (BAND_W + 1)'((1 << (DIFF_W - 1)) - 1)) begin
            diff_sat = DIFF_W'((1 << (DIFF_W - 1)) - 1);
        end else if (diff_raw < -(BAND_W + 1)'((1 << (DIFF_W - 1)) - 1)) begin
            diff_sat = -DIFF_W'((1 << (DIFF_W - 1)) - 1);
        end else begin
            diff_sat = diff_raw[DIFF_W-1:0];
        end
    end

    assign last_col = r_addr == i_col_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        o_ctl.pop      = 1'b0;
        o_ctl.clearing = 1'b0;
        mv_we          = 1'b0;
        bd_we          = 1'b0;
        bd_wdata       = {band_lo, band_hi};
        recip_start    = 1'b0;
        sqrt_start     = 1'b0;
        unique case (r_state)
            BK_CLEAR: begin
                o_ctl.clearing = 1'b1;
                mv_we          = 1'b1;
                bd_we          = 1'b1;
                bd_wdata       = '0;
                if (r_addr == ADDR_W'(MAX_COLUMNS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (i_head.not_empty) begin
                    o_ctl.pop = 1'b1;
                    case (i_head.cmd.kind)
                        CMD_TRAIN:  n_state = BK_TRAIN_RD;
                        CMD_ROWS:   n_state = BK_ROWS;
                        CMD_FINISH: n_state = BK_FIN_RD;
                        CMD_CHECK:  n_state = BK_CHK_RD;
                        default:    n_state = BK_IDLE;
                    endcase
                end
            end
            BK_TRAIN_RD: n_state = BK_TRAIN_D;
            BK_TRAIN_D:  n_state = BK_TRAIN_SQ;
            BK_TRAIN_SQ: n_state = BK_DIV_MUL;
            BK_DIV_MUL:  n_state = BK_DIV_BACK;
            BK_DIV_BACK: n_state = BK_DIV_FIX;
            BK_DIV_FIX: begin
                if (r_job == JOB_SCALE || (r_job == JOB_SPREAD && r_rows == '0)) begin
                    n_state = BK_TRAIN_WR;
                end else begin
                    n_state = BK_DIV_MUL;
                end
            end
            BK_TRAIN_WR: begin
                mv_we   = 1'b1;
                n_state = r_eor ? BK_ROWS : BK_IDLE;
            end
            BK_ROWS: begin
                if (r_rows != ROWS_MAX) begin
                    recip_start = 1'b1;
                    n_state     = BK_RECIP;
                end else begin
                    n_state = BK_IDLE;
                end
            end
            BK_RECIP: begin
                if (recip_done) begin
                    n_state = BK_IDLE;
                end
            end
            BK_FIN_RD: n_state = BK_FIN_ROOT;
            BK_FIN_ROOT: begin
                sqrt_start = 1'b1;
                n_state    = BK_FIN_WAIT;
            end
            BK_FIN_WAIT: begin
                if (sqrt_done) begin
                    n_state = BK_FIN_MUL;
                end
            end
            BK_FIN_MUL: n_state = BK_FIN_BAND;
            BK_FIN_BAND: begin
                bd_we   = 1'b1;
                n_state = last_col ? BK_IDLE : BK_FIN_RD;
            end
            BK_CHK_RD:  n_state = BK_CHK_OUT;
            BK_CHK_OUT: n_state = BK_IDLE;
            default:    n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rows   <= '0;
            r_rk     <= RECIP_W'(1) << RECIP_SHIFT;
            r_rkm1   <= RECIP_W'(1) << RECIP_SHIFT;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_state == BK_CHK_OUT;
            case (r_state)
                BK_CLEAR: begin
                    r_addr <= r_addr + ADDR_W'(1);
                end
                BK_IDLE: begin
                    if (i_head.not_empty) begin
                        if (i_head.cmd.kind == CMD_FINISH) begin
                            r_addr <= '0;
                        end else begin
                            r_addr <= ADDR_W'(i_head.cmd.column);
                        end
                        if (i_head.cmd.kind == CMD_RESTART) begin
                            r_rows <= '0;
                            r_rk   <= RECIP_W'(1) << RECIP_SHIFT;
                        end
                    end
                end
                BK_ROWS: begin
                    // The old 1/k becomes 1/(k-1) for the next row.
                    if (r_rows != ROWS_MAX) begin
                        r_rows <= r_rows + ROWS_W'(1);
                        r_rkm1 <= r_rk;
                    end
                end
                BK_RECIP: begin
                    if (recip_done) begin
                        r_rk <= recip_quot;
                    end
                end
                BK_FIN_BAND: begin
                    if (!last_col) begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_pixel <= i_head.cmd.pixel;
                r_eor   <= i_head.cmd.end_of_row;
            end
            BK_TRAIN_D: begin
                r_mean_old <= r_mv_q[MV_W-1:VAR_W];
                r_var_old  <= r_mv_q[VAR_W-1:0];
                r_d        <= signed'({1'b0, r_pixel, {MEAN_FRAC{1'b0}}})
                              - signed'({1'b0, r_mv_q[MV_W-1:VAR_W]});
            end
            BK_TRAIN_SQ: begin
                r_sq  <= dd * dd;
                r_job <= JOB_MEAN;
            end
            BK_DIV_MUL: begin
                r_num  <= num;
                r_den  <= den;
                r_prod <= num * recip;
            end
            BK_DIV_BACK: begin
                r_q0 <= r_prod[RECIP_SHIFT +: NUM_W];
                r_qk <= NUM_W'(r_prod[RECIP_SHIFT +: NUM_W] * r_den);
            end
            BK_DIV_FIX: begin
                case (r_job)
                    JOB_MEAN:   r_qm  <= q_fixed;
                    JOB_SPREAD: r_qt2 <= q_fixed;
                    default:    r_qt1 <= q_fixed;
                endcase
                r_job <= r_job + 2'd1;
            end
            BK_FIN_ROOT: begin
                r_mean_old <= r_mv_q[MV_W-1:VAR_W];
            end
            BK_FIN_WAIT: begin
                r_sd <= SD_W'(((SD_W + 1)'(sqrt_root) + (SD_W + 1)'(1)) >> 1);
            end
            BK_FIN_MUL: begin
                r_half <= r_sd * i_gain;
            end
            BK_CHK_OUT: begin
                r_diff <= diff_sat;
                r_oob  <= diff_sat != '0;
            end
            default: begin
            end
        endcase
    end

    assign o_strobe      = r_strobe;
    assign o_pixel_diff  = r_diff;
    assign o_out_of_band = r_oob;

endmodule

`default_nettype wire

FILE: rtl/core/column_mean_sigma_band_check.sv
// ----------------------------------------------------------------------------
// Column mean and sigma band check
// Per-column running mean and variance of training pixels, band building
// at mean -/+ gain * sigma, and band checks of pixels.
// ----------------------------------------------------------------------------
//  Channel   Handshake                      Payload
//  command   i_start, o_busy                i_operation, i_column, i_pixel, i_end_of_row
//  result    o_strobe (one cycle)           o_pixel_diff, o_out_of_band
//  config    i_cfg_valid, o_cfg_ready       i_cfg_index, i_cfg_data
//
//  A train item skips the variance scaling division on the first row, and one
//  that ends a row also starts the serial reciprocal divider.
//  A finish item reads each column in use in turn and waits on the square
//  root unit for each; with the back end idle, a check's result strobe comes
//  from the strobe register after the BK_CHK_RD and BK_CHK_OUT states.
//  After reset a clearing pass over all MAX_COLUMNS addresses zeroes the column
//  memories, with o_busy high. A four-entry queue lets commands be taken while
//  the back end works; results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module column_mean_sigma_band_check #(
    parameter int MAX_COLUMNS = 4096
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic [1:0]                        i_operation,
    input  logic [cms_pkg::COL_W-1:0]         i_column,
    input  logic [cms_pkg::PIXEL_BITS-1:0]    i_pixel,
    input  logic                              i_end_of_row,
    output logic                              o_strobe,
    output logic signed [cms_pkg::DIFF_W-1:0] o_pixel_diff,
    output logic                              o_out_of_band,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [cms_pkg::CC_W-1:0]          i_cfg_data
);
    import cms_pkg::*;

    localparam int ADDR_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    logic [CC_W-1:0]   r_column_count;
    logic [GAIN_W-1:0] r_sigma_gain;
    logic [15:0]       cols_n;
    logic [ADDR_W-1:0] col_last;
    logic [GAIN_W-1:0] gain;
    t_queue_head       head;
    t_back_ctl         back_ctl;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column_count <= CC_RESET;
            r_sigma_gain   <= GAIN_RESET;
        end else if (i_cfg_valid) begin
            if (t_cfg_index'(i_cfg_index) == CFG_COLUMN_COUNT) begin
                r_column_count <= i_cfg_data;
            end else begin
                r_sigma_gain <= i_cfg_data[GAIN_W-1:0];
            end
        end
    end

    always_comb begin
        if (r_column_count == '0) begin
            cols_n = 16'd1;
        end else if (16'(r_column_count) > 16'(MAX_COLUMNS)) begin
            cols_n = 16'(MAX_COLUMNS);
        end else begin
            cols_n = 16'(r_column_count);
        end
        col_last = ADDR_W'(cols_n - 16'd1);

        if (r_sigma_gain < GAIN_MIN) begin
            gain = GAIN_MIN;
        end else if (r_sigma_gain > GAIN_MAX) begin
            gain = GAIN_MAX;
        end else begin
            gain = r_sigma_gain;
        end
    end

    cms_front #(
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_operation  (i_operation),
        .i_column     (i_column),
        .i_pixel      (i_pixel),
        .i_end_of_row (i_end_of_row),
        .i_col_last   (col_last),
        .i_back       (back_ctl),
        .o_head       (head)
    );

    cms_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_ctl         (back_ctl),
        .i_col_last    (col_last),
        .i_gain        (gain),
        .o_strobe      (o_strobe),
        .o_pixel_diff  (o_pixel_diff),
        .o_out_of_band (o_out_of_band)
    );

endmodule

`default_nettype wire
